[rtl/cna_pkg.sv]
// ============================================================================
// cna_pkg
// Shared types, constants and arithmetic helpers for the complex number ALU.
// ============================================================================
package cna_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ProdBits  = 2 * WordBits;
  localparam int unsigned SumBits   = ProdBits + 2;
  localparam int unsigned DivBits   = ProdBits + FracBits;
  localparam int unsigned QBits     = WordBits + 1;
  localparam int unsigned SqrtSteps = WordBits;
  localparam int unsigned StepBits  = $clog2(DivBits + 1);
  localparam int unsigned FifoDepth = 2;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [SumBits-1:0]  sum_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_MOD = 3'd5
  } opcode_e;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_DIVZ,
    K_EQ,
    K_MOD,
    K_NONE
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0] opcode;
    word_t      a_re;
    word_t      a_im;
    word_t      b_re;
    word_t      b_im;
  } in_item_t;

  typedef struct packed {
    word_t      res_re;
    word_t      res_im;
    logic       is_equal;
    logic [1:0] status;
  } out_item_t;

  // Queue entry between front and back
  typedef struct packed {
    kind_e kind;
    word_t a_re;
    word_t a_im;
    word_t b_re;
    word_t b_im;
  } job_t;

  typedef struct packed {
    word_t w;
    logic  sat;
  } sat_t;

  localparam sum_t  SumMax  = sum_t'({1'b0, {(WordBits-1){1'b1}}});
  localparam sum_t  SumMin  = -SumMax - sum_t'(1);
  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

  // Clamp a wide signed value to the word range
  function automatic sat_t saturate(sum_t v);
    sat_t r;
    r.sat = 1'b0;
    if (v > SumMax) begin
      r.w   = WordMax;
      r.sat = 1'b1;
    end else if (v < SumMin) begin
      r.w   = WordMin;
      r.sat = 1'b1;
    end else begin
      r.w = v[WordBits-1:0];
    end
    return r;
  endfunction

  // Drop the fraction bits, truncating toward zero
  function automatic sum_t shr_frac(sum_t v);
    sum_t m;
    m = v[SumBits-1] ? -v : v;
    m = m >>> FracBits;
    return v[SumBits-1] ? -m : m;
  endfunction

  // Magnitude of a sum of two products (always below 2^64)
  function automatic logic [ProdBits-1:0] mag_of(sum_t v);
    sum_t m;
    m = v[SumBits-1] ? -v : v;
    return m[ProdBits-1:0];
  endfunction

endpackage

[rtl/cna_stream_if.sv]
// ============================================================================
// cna_stream_if
// Valid/ready stream channel carrying one payload of type T.
// ============================================================================
interface cna_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/cna_front.sv]
// ============================================================================
// cna_front
// Input stage: accepts transactions, classifies the opcode, registers the job.
// ============================================================================
module cna_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  cna_stream_if.sink        in_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output cna_pkg::job_t     job_o
);

  logic          vld_q;
  cna_pkg::job_t job_q;
  cna_pkg::job_t job_d;
  logic          accept;

  assign in_i.ready  = !vld_q || job_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  // Opcode decode, divide by zero is split off here
  always_comb begin
    job_d.a_re = in_i.data.a_re;
    job_d.a_im = in_i.data.a_im;
    job_d.b_re = in_i.data.b_re;
    job_d.b_im = in_i.data.b_im;
    unique case (cna_pkg::opcode_e'(in_i.data.opcode))
      cna_pkg::OP_ADD: job_d.kind = cna_pkg::K_ADD;
      cna_pkg::OP_SUB: job_d.kind = cna_pkg::K_SUB;
      cna_pkg::OP_MUL: job_d.kind = cna_pkg::K_MUL;
      cna_pkg::OP_DIV: begin
        if (in_i.data.b_re == '0 && in_i.data.b_im == '0) begin
          job_d.kind = cna_pkg::K_DIVZ;
        end else begin
          job_d.kind = cna_pkg::K_DIV;
        end
      end
      cna_pkg::OP_EQ:  job_d.kind = cna_pkg::K_EQ;
      cna_pkg::OP_MOD: job_d.kind = cna_pkg::K_MOD;
      default:         job_d.kind = cna_pkg::K_NONE;
    endcase
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (job_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

[rtl/cna_fifo.sv]
// ============================================================================
// cna_fifo
// Short job queue decoupling the front end from the execution back end.
// ============================================================================
module cna_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cna_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cna_pkg::job_t pop_data_o
);

  localparam int unsigned PtrBits = (cna_pkg::FifoDepth > 1) ? $clog2(cna_pkg::FifoDepth) : 1;
  localparam int unsigned CntBits = $clog2(cna_pkg::FifoDepth + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(cna_pkg::FifoDepth - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(cna_pkg::FifoDepth);

  cna_pkg::job_t      mem_q [cna_pkg::FifoDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;
  logic               push, pop;

  assign push_ready_o = cnt_q != CntFull;
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrBits'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrBits'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue fill count beyond depth");

endmodule

[rtl/cna_back.sv]
// ============================================================================
// cna_back
// Execution back end: product stage, single-pass finish for add, subtract,
// multiply, compare and divide by zero, and a shared shift-subtract unit for
// divide and modulus. Results leave through a registered output stage.
// ============================================================================
module cna_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  cna_pkg::job_t job_i,
  cna_stream_if.source  out_o
);

  localparam int unsigned W  = cna_pkg::WordBits;
  localparam int unsigned PB = cna_pkg::ProdBits;
  localparam int unsigned DB = cna_pkg::DivBits;
  localparam int unsigned QB = cna_pkg::QBits;
  localparam int unsigned SB = cna_pkg::StepBits;

  typedef enum logic [1:0] {
    IT_IDLE,
    IT_DIV,
    IT_SQRT,
    IT_DONE
  } it_state_e;

  // Product stage
  logic             p_vld_q;
  cna_pkg::kind_e   p_kind_q;
  cna_pkg::word_t   p_a_re_q, p_a_im_q, p_b_re_q, p_b_im_q;
  cna_pkg::prod_t   p_prod_q [6];

  // Iterative unit
  it_state_e        it_state_q, it_state_d;
  logic [SB-1:0]    it_cnt_q;
  logic             it_mod_q;
  logic [PB-1:0]    den_q;
  logic [DB-1:0]    dvd_re_q, dvd_im_q;
  logic [PB-1:0]    rem_re_q, rem_im_q;
  logic [QB-1:0]    q_re_q, q_im_q;
  logic             big_re_q, big_im_q, neg_re_q, neg_im_q;
  logic [PB-1:0]    sx_q, rt_q, sbit_q;

  // Output stage
  logic               out_vld_q;
  cna_pkg::out_item_t out_q;

  logic               load_p, p_is_iter, it_busy, out_free;
  logic               fast_fire, it_start, it_wr, it_last;
  cna_pkg::out_item_t fast_res, it_res;
  cna_pkg::sum_t      n_re, n_im;

  assign p_is_iter   = p_kind_q == cna_pkg::K_DIV || p_kind_q == cna_pkg::K_MOD;
  assign it_busy     = it_state_q != IT_IDLE;
  assign out_free    = !out_vld_q || out_o.ready;
  assign fast_fire   = p_vld_q && !p_is_iter && !it_busy && out_free;
  assign it_start    = p_vld_q && p_is_iter && !it_busy;
  assign it_wr       = it_state_q == IT_DONE && out_free;
  assign it_last     = it_cnt_q == '0;
  assign job_ready_o = !p_vld_q || fast_fire || it_start;
  assign load_p      = job_valid_i && job_ready_o;

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Numerators for divide (conjugate of B)
  assign n_re = cna_pkg::sum_t'(p_prod_q[0]) + cna_pkg::sum_t'(p_prod_q[1]);
  assign n_im = cna_pkg::sum_t'(p_prod_q[3]) - cna_pkg::sum_t'(p_prod_q[2]);

  // Product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (job_ready_o) begin
      p_vld_q <= job_valid_i;
    end
  end

  // Product stage payload: six parallel 32x32 products
  always_ff @(posedge clk_i) begin
    if (load_p) begin
      p_kind_q <= job_i.kind;
      p_a_re_q <= job_i.a_re;
      p_a_im_q <= job_i.a_im;
      p_b_re_q <= job_i.b_re;
      p_b_im_q <= job_i.b_im;
      if (job_i.kind == cna_pkg::K_MOD) begin
        p_prod_q[0] <= job_i.a_re * job_i.a_re;
        p_prod_q[1] <= job_i.a_im * job_i.a_im;
      end else begin
        p_prod_q[0] <= job_i.a_re * job_i.b_re;
        p_prod_q[1] <= job_i.a_im * job_i.b_im;
      end
      p_prod_q[2] <= job_i.a_re * job_i.b_im;
      p_prod_q[3] <= job_i.a_im * job_i.b_re;
      p_prod_q[4] <= job_i.b_re * job_i.b_re;
      p_prod_q[5] <= job_i.b_im * job_i.b_im;
    end
  end

  // Single-pass results
  always_comb begin
    cna_pkg::sum_t s_re;
    cna_pkg::sum_t s_im;
    cna_pkg::sat_t c_re;
    cna_pkg::sat_t c_im;
    s_re              = '0;
    s_im              = '0;
    fast_res.is_equal = 1'b0;
    fast_res.status   = cna_pkg::ST_OK;
    case (p_kind_q)
      cna_pkg::K_ADD: begin
        s_re = cna_pkg::sum_t'(p_a_re_q) + cna_pkg::sum_t'(p_b_re_q);
        s_im = cna_pkg::sum_t'(p_a_im_q) + cna_pkg::sum_t'(p_b_im_q);
      end
      cna_pkg::K_SUB: begin
        s_re = cna_pkg::sum_t'(p_a_re_q) - cna_pkg::sum_t'(p_b_re_q);
        s_im = cna_pkg::sum_t'(p_a_im_q) - cna_pkg::sum_t'(p_b_im_q);
      end
      cna_pkg::K_MUL: begin
        s_re = cna_pkg::shr_frac(cna_pkg::sum_t'(p_prod_q[0]) - cna_pkg::sum_t'(p_prod_q[1]));
        s_im = cna_pkg::shr_frac(cna_pkg::sum_t'(p_prod_q[2]) + cna_pkg::sum_t'(p_prod_q[3]));
      end
      cna_pkg::K_EQ: begin
        fast_res.is_equal = (p_a_re_q == p_b_re_q) && (p_a_im_q == p_b_im_q);
      end
      cna_pkg::K_DIVZ: begin
        fast_res.status = cna_pkg::ST_DIV_ZERO;
      end
      default: begin
      end
    endcase
    c_re            = cna_pkg::saturate(s_re);
    c_im            = cna_pkg::saturate(s_im);
    fast_res.res_re = c_re.w;
    fast_res.res_im = c_im.w;
    if (fast_res.status == cna_pkg::ST_OK && (c_re.sat || c_im.sat)) begin
      fast_res.status = cna_pkg::ST_SAT;
    end
  end

  // Quotient to word, with saturation
  function automatic cna_pkg::sat_t quot_word(logic [QB-1:0] q, logic big, logic neg);
    cna_pkg::sat_t r;
    if (neg) begin
      r.sat = big || q[QB-1] || (q[W-1] && q[W-2:0] != '0);
      r.w   = r.sat ? cna_pkg::WordMin : cna_pkg::word_t'(-q[W-1:0]);
    end else begin
      r.sat = big || q[QB-1] || q[W-1];
      r.w   = r.sat ? cna_pkg::WordMax : cna_pkg::word_t'(q[W-1:0]);
    end
    return r;
  endfunction

  // Result of the iterative unit
  always_comb begin
    cna_pkg::sat_t c_re;
    cna_pkg::sat_t c_im;
    it_res.is_equal = 1'b0;
    if (it_mod_q) begin
      c_re.sat = rt_q[PB-1:W-1] != '0;
      c_re.w   = c_re.sat ? cna_pkg::WordMax : cna_pkg::word_t'(rt_q[W-1:0]);
      c_im.sat = 1'b0;
      c_im.w   = '0;
    end else begin
      c_re = quot_word(q_re_q, big_re_q, neg_re_q);
      c_im = quot_word(q_im_q, big_im_q, neg_im_q);
    end
    it_res.res_re = c_re.w;
    it_res.res_im = c_im.w;
    it_res.status = (c_re.sat || c_im.sat) ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
  end

  // Iterative unit sequencing
  always_comb begin
    it_state_d = it_state_q;
    unique case (it_state_q)
      IT_IDLE: begin
        if (it_start) begin
          it_state_d = (p_kind_q == cna_pkg::K_MOD) ? IT_SQRT : IT_DIV;
        end
      end
      IT_DIV, IT_SQRT: begin
        if (it_last) begin
          it_state_d = IT_DONE;
        end
      end
      IT_DONE: begin
        if (out_free) begin
          it_state_d = IT_IDLE;
        end
      end
      default: it_state_d = IT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_state_q <= IT_IDLE;
    end else begin
      it_state_q <= it_state_d;
    end
  end

  // Iterative datapath: one quotient bit per lane or one root bit per cycle
  always_ff @(posedge clk_i) begin
    logic [PB:0] rn_re;
    logic [PB:0] rn_im;
    logic [PB-1:0] t;
    rn_re = {rem_re_q, dvd_re_q[DB-1]};
    rn_im = {rem_im_q, dvd_im_q[DB-1]};
    t     = rt_q + sbit_q;
    if (it_start) begin
      it_mod_q <= p_kind_q == cna_pkg::K_MOD;
      den_q    <= p_prod_q[4][PB-1:0] + p_prod_q[5][PB-1:0];
      dvd_re_q <= {cna_pkg::mag_of(n_re), {cna_pkg::FracBits{1'b0}}};
      dvd_im_q <= {cna_pkg::mag_of(n_im), {cna_pkg::FracBits{1'b0}}};
      neg_re_q <= n_re[cna_pkg::SumBits-1];
      neg_im_q <= n_im[cna_pkg::SumBits-1];
      rem_re_q <= '0;
      rem_im_q <= '0;
      q_re_q   <= '0;
      q_im_q   <= '0;
      big_re_q <= 1'b0;
      big_im_q <= 1'b0;
      sx_q     <= p_prod_q[0][PB-1:0] + p_prod_q[1][PB-1:0];
      rt_q     <= '0;
      sbit_q   <= PB'(1) << (PB - 2);
      it_cnt_q <= (p_kind_q == cna_pkg::K_MOD) ? SB'(cna_pkg::SqrtSteps - 1) : SB'(DB - 1);
    end else if (it_state_q == IT_DIV) begin
      if (rn_re >= {1'b0, den_q}) begin
        rem_re_q <= PB'(rn_re - {1'b0, den_q});
        q_re_q   <= {q_re_q[QB-2:0], 1'b1};
      end else begin
        rem_re_q <= rn_re[PB-1:0];
        q_re_q   <= {q_re_q[QB-2:0], 1'b0};
      end
      if (rn_im >= {1'b0, den_q}) begin
        rem_im_q <= PB'(rn_im - {1'b0, den_q});
        q_im_q   <= {q_im_q[QB-2:0], 1'b1};
      end else begin
        rem_im_q <= rn_im[PB-1:0];
        q_im_q   <= {q_im_q[QB-2:0], 1'b0};
      end
      big_re_q <= big_re_q | q_re_q[QB-1];
      big_im_q <= big_im_q | q_im_q[QB-1];
      dvd_re_q <= dvd_re_q << 1;
      dvd_im_q <= dvd_im_q << 1;
      it_cnt_q <= it_cnt_q - SB'(1);
    end else if (it_state_q == IT_SQRT) begin
      if (sx_q >= t) begin
        sx_q <= sx_q - t;
        rt_q <= (rt_q >> 1) + sbit_q;
      end else begin
        rt_q <= rt_q >> 1;
      end
      sbit_q   <= sbit_q >> 2;
      it_cnt_q <= it_cnt_q - SB'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fast_fire || it_wr) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (it_wr) begin
      out_q <= it_res;
    end else if (fast_fire) begin
      out_q <= fast_res;
    end
  end

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fast_fire && it_wr))
    else $error("output register written by both paths");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_start |=> it_state_q != IT_IDLE)
    else $error("iterative unit did not start");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (it_state_q == IT_DONE && it_mod_q) |-> rt_q[PB-1:W+1] == '0)
    else $error("square root result out of range");

endmodule

[rtl/complex_number_alu.sv]
// Add, subtract, multiply and compare pass the front register, the job queue,
// the product stage and the output register. Divide and modulus also pass the
// shared shift-subtract unit (80 quotient steps or 32 root steps, one per cycle).
// Throughput: one transaction per cycle while the output accepts, for all but
// divide and modulus, which hold the back end for their whole iteration.
// Reset clears all valid flags, the job queue and the divide/root sequencer.
// ============================================================================
// complex_number_alu
// Q16.16 complex arithmetic unit: front end, job queue and execution back end.
// ============================================================================
module complex_number_alu (
  input  logic         clk_i,
  input  logic         rst_ni,
  cna_stream_if.sink   in_i,
  cna_stream_if.source out_o
);

  logic          f_valid, f_ready;
  cna_pkg::job_t f_job;
  logic          q_valid, q_ready;
  cna_pkg::job_t q_job;

  cna_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  cna_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  cna_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_o       (out_o)
  );

endmodule

[tb/complex_number_alu_tb.sv]
// ============================================================================
// complex_number_alu_tb
// Self-checking bench for the Q16.16 complex ALU. Directed corner operands,
// then randomly weighted operations and operands. Both stream sides stall at
// random. Results are compared with an internal exact-arithmetic predictor.
// ============================================================================
module complex_number_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef bit signed [159:0]    wide_t;
  typedef cna_pkg::word_t       word_t;
  typedef cna_pkg::in_item_t    in_item_t;
  typedef cna_pkg::out_item_t   out_item_t;

  localparam word_t      WordMax   = cna_pkg::WordMax;
  localparam word_t      WordMin   = cna_pkg::WordMin;
  localparam logic [2:0] OpAdd     = cna_pkg::OP_ADD;
  localparam logic [2:0] OpSub     = cna_pkg::OP_SUB;
  localparam logic [2:0] OpMul     = cna_pkg::OP_MUL;
  localparam logic [2:0] OpDiv     = cna_pkg::OP_DIV;
  localparam logic [2:0] OpEq      = cna_pkg::OP_EQ;
  localparam logic [2:0] OpMod     = cna_pkg::OP_MOD;
  localparam logic [2:0] OpSpare6  = 3'd6;
  localparam logic [2:0] OpSpare7  = 3'd7;
  localparam int         NumRandom = 1580;
  localparam int         WdLimit   = 5000;

  // Expected results of accepted transactions, oldest first
  class alu_scoreboard;
    out_item_t pending_q[$];
    int        errors;
    bit        clipped;

    function new();
      errors = 0;
    endfunction

    // Clamp to the signed word range, noting any clipping
    function word_t clamp(wide_t v);
      if (v > wide_t'(WordMax)) begin
        clipped = 1'b1;
        return WordMax;
      end
      if (v < wide_t'(WordMin)) begin
        clipped = 1'b1;
        return WordMin;
      end
      return word_t'(v);
    endfunction

    function wide_t int_sqrt(wide_t x);
      wide_t r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (wide_t'(1) <<< i);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function out_item_t predict(in_item_t it);
      wide_t     a, b, c, d, re, im, den;
      wide_t     scale;
      bit        dz;
      out_item_t r;
      scale = 65536;
      a = it.a_re; b = it.a_im; c = it.b_re; d = it.b_im;
      re = 0; im = 0; dz = 0; clipped = 0;
      r = '0;
      case (it.opcode)
        OpAdd: begin re = a + c; im = b + d; end
        OpSub: begin re = a - c; im = b - d; end
        OpMul: begin
          re = (a * c - b * d) / scale;
          im = (a * d + b * c) / scale;
        end
        OpDiv: begin
          if (c == 0 && d == 0) begin
            dz = 1;
          end else begin
            den = c * c + d * d;
            re = ((a * c + b * d) * scale) / den;
            im = ((b * c - a * d) * scale) / den;
          end
        end
        OpEq:  r.is_equal = (a == c) && (b == d);
        OpMod: re = int_sqrt(a * a + b * b);
        default: ;
      endcase
      r.res_re = clamp(re);
      r.res_im = clamp(im);
      r.status = dz ? cna_pkg::ST_DIV_ZERO : (clipped ? cna_pkg::ST_SAT : cna_pkg::ST_OK);
      return r;
    endfunction

    function void note_input(in_item_t it);
      pending_q.push_back(predict(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.res_re !== exp_r.res_re) begin
        $display("%0t: res_re exp %h got %h", $time, exp_r.res_re, got.res_re);
        errors++;
      end
      if (got.res_im !== exp_r.res_im) begin
        $display("%0t: res_im exp %h got %h", $time, exp_r.res_im, got.res_im);
        errors++;
      end
      if (got.is_equal !== exp_r.is_equal) begin
        $display("%0t: is_equal exp %b got %b", $time, exp_r.is_equal, got.is_equal);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cna_stream_if #(.T(in_item_t))  in_if ();
  cna_stream_if #(.T(out_item_t)) out_if ();

  complex_number_alu u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  alu_scoreboard sb = new();
  bit no_stall   = 0;
  int sent_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic word_t rand_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom);
      4, 5:       return word_t'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      6: begin
        case ($urandom_range(0, 4))
          0: return WordMin;
          1: return WordMax;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return word_t'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
    endcase
  endfunction

  function automatic in_item_t make_item(logic [2:0] op, word_t ar, word_t ai,
                                         word_t br, word_t bi);
    in_item_t it;
    it.opcode = op;
    it.a_re = ar; it.a_im = ai; it.b_re = br; it.b_im = bi;
    return it;
  endfunction

  // Offer one transaction, with a random gap ahead of it
  task automatic send_item(in_item_t it);
    while (!no_stall && $urandom_range(0, 99) < 38) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    sent_count++;
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    in_item_t dir_q[$];
    logic [2:0] op;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    dir_q.push_back(make_item(OpAdd, WordMax, WordMax, WordMax, 1));
    dir_q.push_back(make_item(OpAdd, WordMin, WordMin, -1, WordMin));
    dir_q.push_back(make_item(OpSub, WordMin, WordMax, 1, -1));
    dir_q.push_back(make_item(OpSub, 32'h0003_0000, -32'h0001_8000, 32'h0001_0000, 5));
    dir_q.push_back(make_item(OpMul, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, -32'h1_0000));
    dir_q.push_back(make_item(OpMul, WordMin, WordMin, WordMin, WordMin));
    dir_q.push_back(make_item(OpMul, WordMax, WordMin, WordMax, WordMax));
    dir_q.push_back(make_item(OpMul, -3, 7, 5, -1));
    dir_q.push_back(make_item(OpDiv, 32'h0001_0000, 32'h0001_0000, 0, 0));
    dir_q.push_back(make_item(OpDiv, WordMax, WordMin, 0, 0));
    dir_q.push_back(make_item(OpDiv, WordMax, WordMax, 1, 0));
    dir_q.push_back(make_item(OpDiv, WordMin, 0, 0, -1));
    dir_q.push_back(make_item(OpDiv, 32'h0006_0000, -32'h0002_0000, 32'h0001_0000, 32'h1_0000));
    dir_q.push_back(make_item(OpDiv, 1, -1, WordMin, WordMax));
    dir_q.push_back(make_item(OpEq, WordMin, WordMax, WordMin, WordMax));
    dir_q.push_back(make_item(OpEq, 5, 6, 5, 7));
    dir_q.push_back(make_item(OpEq, 0, 0, 0, 0));
    dir_q.push_back(make_item(OpMod, WordMin, WordMin, 0, 0));
    dir_q.push_back(make_item(OpMod, 32'h0003_0000, -32'h0004_0000, 9, 9));
    dir_q.push_back(make_item(OpMod, 0, 0, 0, 0));
    dir_q.push_back(make_item(OpMod, WordMax, 0, 1, 1));
    dir_q.push_back(make_item(OpSpare6, WordMax, WordMin, -1, 1));
    dir_q.push_back(make_item(OpSpare7, WordMin, WordMax, 1, -1));
    foreach (dir_q[i]) send_item(dir_q[i]);

    for (int n = 0; n < NumRandom; n++) begin
      no_stall = (n >= 600 && n < 800);
      if (n == 1000) begin
        // let the pipeline empty completely
        in_if.valid <= 1'b0;
        wait_drained();
        @(posedge clk_i);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3:    op = OpAdd;
        4, 5, 6, 7:    op = OpSub;
        8, 9, 10, 11:  op = OpMul;
        12, 13:        op = OpDiv;
        14, 15:        op = OpEq;
        16, 17:        op = OpMod;
        18:            op = OpSpare6;
        default:       op = OpSpare7;
      endcase
      if (op == OpEq && $urandom_range(0, 1)) begin
        word_t xr, xi;
        xr = rand_operand();
        xi = rand_operand();
        send_item(make_item(op, xr, xi, xr, ($urandom_range(0, 3) == 0) ? ~xi : xi));
      end else begin
        send_item(make_item(op, rand_operand(), rand_operand(),
                            rand_operand(), rand_operand()));
      end
    end
    in_if.valid <= 1'b0;
    no_stall = 0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random ready, one long hold-off
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (!hold_done && sent_count >= 300) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_stall || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WdLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/cna_pkg.sv
rtl/cna_stream_if.sv
rtl/cna_front.sv
rtl/cna_fifo.sv
rtl/cna_back.sv
rtl/complex_number_alu.sv
tb/complex_number_alu_tb.sv
